// ===== sv/obb_separating_axis_test_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the oriented box separating axis test block
// Two wrappers around a clocked concurrent assertion, with and without reset.
// ----------------------------------------------------------------------------
`ifndef OBB_SEPARATING_AXIS_TEST_DEFINES_SVH
`define OBB_SEPARATING_AXIS_TEST_DEFINES_SVH

// Clocked assertion that is switched off while reset is held.
`define OBB_ASSERT_CLK(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that is also checked during reset.
`define OBB_ASSERT_RAW(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/obb_sat_pkg.sv =====
// ----------------------------------------------------------------------------
// obb_sat_pkg
// Widths, types and codes shared by the separating axis test modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package obb_sat_pkg;

    // Fixed point format of all coordinates and half extents.
    localparam int FRAC_BITS     = 16;
    localparam int COORD_W       = 32;
    localparam int HALF_W        = 31;
    localparam int AXES_PER_BOX  = 3;

    // Datapath widths; every value is kept exact.
    localparam int DIFF_W        = COORD_W + 1;          // center difference
    localparam int UVEC_W        = 2 * COORD_W + 1;      // cross product component
    localparam int DIG_W         = 32;                   // multiplier digit
    localparam int DIGITS        = 3;
    localparam int MAG_W         = DIG_W * DIGITS;       // magnitude of operand a
    localparam int MA_W          = MAG_W + 1;
    localparam int MB_W          = DIFF_W;
    localparam int PROD_W        = MAG_W + MB_W + 1;
    localparam int ACC_W         = PROD_W + 2;
    localparam int DIST_W        = MAG_W + 1;
    localparam int RAD_W         = ACC_W;

    // Axis numbering: face axes of the first box, of the second box, then crosses.
    localparam int NUM_AXES      = 15;
    localparam int AXIS_W        = $clog2(NUM_AXES);
    localparam int FACE_B_FIRST  = AXES_PER_BOX;
    localparam int CROSS_FIRST   = 2 * AXES_PER_BOX;
    localparam int NUM_EDGES     = 2 * AXES_PER_BOX;
    localparam int EDGE_W        = $clog2(NUM_EDGES + 1);

    localparam int QUEUE_DEPTH   = 2;

    localparam logic [1:0] KIND_CENTER = 2'd0;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [HALF_W-1:0]         half_t;

    // One classified loading item as it travels from front to back.
    typedef struct packed {
        logic       box;
        logic       is_center;
        logic [1:0] slot;
        coord_t     x;
        coord_t     y;
        coord_t     z;
        half_t      h;
        logic       last;
    } cmd_t;

    typedef struct packed {
        logic                     start;
        logic signed [MA_W-1:0]   a;
        logic signed [MB_W-1:0]   b;
    } mul_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [PROD_W-1:0] prod;
    } mul_rsp_t;

    typedef enum logic [1:0] {
        MUL_IDLE,
        MUL_RUN,
        MUL_FIX
    } mul_state_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_INIT,
        B_AXIS,
        B_XMUL,
        B_XWAIT,
        B_DIST,
        B_DWAIT,
        B_PSEL,
        B_PMUL,
        B_PWAIT,
        B_HMUL,
        B_HWAIT,
        B_CMP,
        B_DONE
    } back_state_t;

endpackage

`default_nettype wire

// ===== sv/obb_sat_front.sv =====
// ----------------------------------------------------------------------------
// obb_sat_front
// Accepts loading items, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module obb_sat_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 box,
    input  wire logic [1:0]           kind,
    input  wire obb_sat_pkg::coord_t  x,
    input  wire obb_sat_pkg::coord_t  y,
    input  wire obb_sat_pkg::coord_t  z,
    input  wire obb_sat_pkg::half_t   half_length,
    input  wire logic                 last,
    output logic                      cmd_valid,
    input  wire logic                 cmd_ready,
    output obb_sat_pkg::cmd_t         cmd
);

    localparam int PTR_W = $clog2(obb_sat_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(obb_sat_pkg::QUEUE_DEPTH + 1);

    obb_sat_pkg::cmd_t q_reg [obb_sat_pkg::QUEUE_DEPTH];
    obb_sat_pkg::cmd_t item;
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              push, pop;

    // Classification: centers and axes go to different stores in the back end.
    always_comb
    begin
        item.box       = box;
        item.is_center = (kind == obb_sat_pkg::KIND_CENTER);
        item.slot      = kind - 2'd1;
        item.x         = x;
        item.y         = y;
        item.z         = z;
        item.h         = half_length;
        item.last      = last;
    end

    assign in_ready  = (cnt_reg != CNT_W'(obb_sat_pkg::QUEUE_DEPTH));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(obb_sat_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(obb_sat_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + PTR_W'(1);
        end
        cnt_next = cnt_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

`default_nettype wire

// ===== sv/obb_sat_mul.sv =====
// ----------------------------------------------------------------------------
// obb_sat_mul
// Shared signed multiplier: 96-bit magnitude by 33 bits, one digit a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module obb_sat_mul (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire obb_sat_pkg::mul_req_t req,
    output obb_sat_pkg::mul_rsp_t      rsp
);

    localparam int DCNT_W = $clog2(obb_sat_pkg::DIGITS);
    localparam int MAG_W  = obb_sat_pkg::MAG_W;
    localparam int MB_W   = obb_sat_pkg::MB_W;
    localparam int DIG_W  = obb_sat_pkg::DIG_W;
    localparam int SUM_W  = obb_sat_pkg::PROD_W - 1;

    obb_sat_pkg::mul_state_t state_reg, state_next;

    logic [MAG_W-1:0]                     am_reg;
    logic [MB_W-1:0]                      bm_reg;
    logic                                 neg_reg;
    logic [SUM_W-1:0]                     sum_reg;
    logic [DCNT_W-1:0]                    dig_reg;
    logic signed [obb_sat_pkg::PROD_W-1:0] prod_reg;
    logic                                 done_reg;

    logic signed [obb_sat_pkg::MA_W-1:0]  abs_a;
    logic signed [MB_W-1:0]               abs_b;
    logic [DIG_W+MB_W-1:0]                partial;
    logic [SUM_W-1:0]                     sum_step;
    logic signed [obb_sat_pkg::PROD_W-1:0] sum_ext;
    logic                                 load, step, fix;

    assign abs_a    = req.a[obb_sat_pkg::MA_W-1] ? -req.a : req.a;
    assign abs_b    = req.b[MB_W-1] ? -req.b : req.b;
    // Most significant digit first, so the running sum only shifts by a constant.
    assign partial  = am_reg[MAG_W-1 -: DIG_W] * bm_reg;
    assign sum_step = {sum_reg[SUM_W-DIG_W-1:0], DIG_W'(0)} + SUM_W'(partial);
    assign sum_ext  = $signed({1'b0, sum_reg});

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            obb_sat_pkg::MUL_IDLE:
            begin
                if (req.start)
                begin
                    state_next = obb_sat_pkg::MUL_RUN;
                end
            end
            obb_sat_pkg::MUL_RUN:
            begin
                if (dig_reg == DCNT_W'(obb_sat_pkg::DIGITS - 1))
                begin
                    state_next = obb_sat_pkg::MUL_FIX;
                end
            end
            obb_sat_pkg::MUL_FIX:
            begin
                state_next = obb_sat_pkg::MUL_IDLE;
            end
            default:
            begin
                state_next = obb_sat_pkg::MUL_IDLE;
            end
        endcase
    end

    always_comb
    begin
        load = 1'b0;
        step = 1'b0;
        fix  = 1'b0;
        case (state_reg)
            obb_sat_pkg::MUL_IDLE: load = req.start;
            obb_sat_pkg::MUL_RUN:  step = 1'b1;
            obb_sat_pkg::MUL_FIX:  fix  = 1'b1;
            default:               load = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= obb_sat_pkg::MUL_IDLE;
            dig_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= fix;
            if (load)
            begin
                dig_reg <= '0;
            end
            else if (step)
            begin
                dig_reg <= dig_reg + DCNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            am_reg  <= abs_a[MAG_W-1:0];
            bm_reg  <= abs_b;
            neg_reg <= req.a[obb_sat_pkg::MA_W-1] ^ req.b[MB_W-1];
            sum_reg <= '0;
        end
        else if (step)
        begin
            am_reg  <= {am_reg[MAG_W-DIG_W-1:0], DIG_W'(0)};
            sum_reg <= sum_step;
        end
        if (fix)
        begin
            prod_reg <= neg_reg ? -sum_ext : sum_ext;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.prod = prod_reg;

endmodule

`default_nettype wire

// ===== sv/obb_sat_back.sv =====
// ----------------------------------------------------------------------------
// obb_sat_back
// Box stores and the sequencer that runs the fifteen axis tests.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module obb_sat_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cmd_valid,
    output logic                       cmd_ready,
    input  wire obb_sat_pkg::cmd_t     cmd,
    output obb_sat_pkg::mul_req_t      mul_req,
    input  wire obb_sat_pkg::mul_rsp_t mul_rsp,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic                       collide
);

    localparam int AXIS_W = obb_sat_pkg::AXIS_W;
    localparam int EDGE_W = obb_sat_pkg::EDGE_W;
    localparam int ACC_W  = obb_sat_pkg::ACC_W;
    localparam int RAD_W  = obb_sat_pkg::RAD_W;
    localparam int MAG_W  = obb_sat_pkg::MAG_W;

    function automatic logic [1:0] comp_next(input logic [1:0] c);
        logic [1:0] r;
        case (c)
            2'd0:    r = 2'd1;
            2'd1:    r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    // Index of the first box's axis within a cross product axis number.
    function automatic logic [1:0] cross_a(input logic [AXIS_W-1:0] t);
        logic [AXIS_W-1:0] n;
        logic [1:0]        r;
        n = t - AXIS_W'(obb_sat_pkg::CROSS_FIRST);
        if (n >= AXIS_W'(2 * obb_sat_pkg::AXES_PER_BOX))
            r = 2'd2;
        else if (n >= AXIS_W'(obb_sat_pkg::AXES_PER_BOX))
            r = 2'd1;
        else
            r = 2'd0;
        return r;
    endfunction

    function automatic logic [1:0] cross_b(input logic [AXIS_W-1:0] t);
        logic [AXIS_W-1:0] n;
        logic [AXIS_W-1:0] r;
        n = t - AXIS_W'(obb_sat_pkg::CROSS_FIRST);
        r = n - AXIS_W'(obb_sat_pkg::AXES_PER_BOX) * AXIS_W'(cross_a(t));
        return r[1:0];
    endfunction

    // Whether box axis k contributes to the projected radius on test axis t.
    function automatic logic edge_used(input logic [AXIS_W-1:0] t,
                                       input logic [EDGE_W-1:0] k);
        logic              on_a;
        logic [EDGE_W-1:0] kb;
        logic              r;
        on_a = (k < EDGE_W'(obb_sat_pkg::AXES_PER_BOX));
        kb   = k - EDGE_W'(obb_sat_pkg::AXES_PER_BOX);
        if (t < AXIS_W'(obb_sat_pkg::FACE_B_FIRST))
            r = !on_a;
        else if (t < AXIS_W'(obb_sat_pkg::CROSS_FIRST))
            r = on_a;
        else if (on_a)
            r = (k[1:0] != cross_a(t));
        else
            r = (kb[1:0] != cross_b(t));
        return r;
    endfunction

    obb_sat_pkg::back_state_t state_reg, state_next;

    // Box stores.
    obb_sat_pkg::coord_t ca_reg  [3];
    obb_sat_pkg::coord_t cb_reg  [3];
    obb_sat_pkg::coord_t axa_reg [3][3];
    obb_sat_pkg::coord_t axb_reg [3][3];
    obb_sat_pkg::half_t  ha_reg  [3];
    obb_sat_pkg::half_t  hb_reg  [3];

    // Working registers.
    logic signed [obb_sat_pkg::DIFF_W-1:0] d_reg [3], d_next [3];
    logic signed [obb_sat_pkg::UVEC_W-1:0] u_reg [3], u_next [3];
    logic signed [ACC_W-1:0]               acc_reg, acc_next;
    logic [obb_sat_pkg::DIST_W-1:0]        dist_reg, dist_next;
    logic [RAD_W-1:0]                      rad_reg, rad_next;
    logic [AXIS_W-1:0]                     t_reg, t_next;
    logic [EDGE_W-1:0]                     k_reg, k_next;
    logic [1:0]                            c_reg, c_next;
    logic                                  sub_reg, sub_next;
    logic                                  res_reg, res_next;
    logic                                  out_valid_reg, out_valid_next;
    logic                                  collide_reg, collide_next;

    logic [1:0]              ia, ib;
    obb_sat_pkg::coord_t     axa_rd [3];
    obb_sat_pkg::coord_t     axb_rd [3];
    obb_sat_pkg::half_t      ha_rd, hb_rd;
    logic [1:0]              c1, c2;
    logic signed [ACC_W-1:0] prod_ext;
    logic signed [ACC_W-1:0] dot_sum;
    logic signed [ACC_W-1:0] dot_abs;
    logic signed [ACC_W-1:0] acc_abs;
    logic [RAD_W-1:0]        dist_sh;
    logic                    separated;
    logic                    face_a, face_b, k_on_a;
    logic                    c_last, out_free;
    logic                    store_wr;

    // One read port on each box's axis store, steered by the sequencer state.
    always_comb
    begin
        case (state_reg)
            obb_sat_pkg::B_AXIS:
            begin
                ia = t_reg[1:0];
                ib = 2'(t_reg - AXIS_W'(obb_sat_pkg::FACE_B_FIRST));
            end
            obb_sat_pkg::B_XMUL:
            begin
                ia = cross_a(t_reg);
                ib = cross_b(t_reg);
            end
            default:
            begin
                ia = k_reg[1:0];
                ib = 2'(k_reg - EDGE_W'(obb_sat_pkg::AXES_PER_BOX));
            end
        endcase
    end

    always_comb
    begin
        for (int n = 0; n < 3; n++)
        begin
            axa_rd[n] = axa_reg[ia][n];
            axb_rd[n] = axb_reg[ib][n];
        end
    end

    assign ha_rd     = ha_reg[ia];
    assign hb_rd     = hb_reg[ib];
    assign c1        = comp_next(c_reg);
    assign c2        = comp_next(c1);
    assign c_last    = (c_reg == 2'd2);
    assign prod_ext  = ACC_W'(mul_rsp.prod);
    assign dot_sum   = (c_reg == 2'd0) ? prod_ext : acc_reg + prod_ext;
    assign dot_abs   = dot_sum[ACC_W-1] ? -dot_sum : dot_sum;
    assign acc_abs   = acc_reg[ACC_W-1] ? -acc_reg : acc_reg;
    assign dist_sh   = RAD_W'(dist_reg) << obb_sat_pkg::FRAC_BITS;
    assign separated = (dist_sh > rad_reg);
    assign face_a    = (t_reg < AXIS_W'(obb_sat_pkg::FACE_B_FIRST));
    assign face_b    = !face_a && (t_reg < AXIS_W'(obb_sat_pkg::CROSS_FIRST));
    assign k_on_a    = (k_reg < EDGE_W'(obb_sat_pkg::AXES_PER_BOX));
    assign out_free  = !out_valid_reg || out_ready;
    assign cmd_ready = (state_reg == obb_sat_pkg::B_IDLE);
    assign store_wr  = cmd_valid && cmd_ready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            obb_sat_pkg::B_IDLE:
                if (store_wr && cmd.last)
                    state_next = obb_sat_pkg::B_INIT;
            obb_sat_pkg::B_INIT:
                state_next = obb_sat_pkg::B_AXIS;
            obb_sat_pkg::B_AXIS:
                state_next = (face_a || face_b) ? obb_sat_pkg::B_DIST : obb_sat_pkg::B_XMUL;
            obb_sat_pkg::B_XMUL:
                state_next = obb_sat_pkg::B_XWAIT;
            obb_sat_pkg::B_XWAIT:
                if (mul_rsp.done)
                    state_next = (sub_reg && c_last) ? obb_sat_pkg::B_DIST
                                                     : obb_sat_pkg::B_XMUL;
            obb_sat_pkg::B_DIST:
                state_next = obb_sat_pkg::B_DWAIT;
            obb_sat_pkg::B_DWAIT:
                if (mul_rsp.done)
                    state_next = c_last ? obb_sat_pkg::B_PSEL : obb_sat_pkg::B_DIST;
            obb_sat_pkg::B_PSEL:
                if (k_reg == EDGE_W'(obb_sat_pkg::NUM_EDGES))
                    state_next = obb_sat_pkg::B_CMP;
                else if (edge_used(t_reg, k_reg))
                    state_next = obb_sat_pkg::B_PMUL;
            obb_sat_pkg::B_PMUL:
                state_next = obb_sat_pkg::B_PWAIT;
            obb_sat_pkg::B_PWAIT:
                if (mul_rsp.done)
                    state_next = c_last ? obb_sat_pkg::B_HMUL : obb_sat_pkg::B_PMUL;
            obb_sat_pkg::B_HMUL:
                state_next = obb_sat_pkg::B_HWAIT;
            obb_sat_pkg::B_HWAIT:
                if (mul_rsp.done)
                    state_next = obb_sat_pkg::B_PSEL;
            obb_sat_pkg::B_CMP:
                if (separated || t_reg == AXIS_W'(obb_sat_pkg::NUM_AXES - 1))
                    state_next = obb_sat_pkg::B_DONE;
                else
                    state_next = obb_sat_pkg::B_AXIS;
            obb_sat_pkg::B_DONE:
                if (out_free)
                    state_next = obb_sat_pkg::B_IDLE;
            default:
                state_next = obb_sat_pkg::B_IDLE;
        endcase
    end

    // Datapath and multiplier requests.
    always_comb
    begin
        d_next         = d_reg;
        u_next         = u_reg;
        acc_next       = acc_reg;
        dist_next      = dist_reg;
        rad_next       = rad_reg;
        t_next         = t_reg;
        k_next         = k_reg;
        c_next         = c_reg;
        sub_next       = sub_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !out_ready;
        collide_next   = collide_reg;
        mul_req        = '0;
        case (state_reg)
            obb_sat_pkg::B_INIT:
            begin
                for (int n = 0; n < 3; n++)
                begin
                    d_next[n] = obb_sat_pkg::DIFF_W'(ca_reg[n])
                              - obb_sat_pkg::DIFF_W'(cb_reg[n]);
                end
                t_next = '0;
            end
            obb_sat_pkg::B_AXIS:
            begin
                c_next   = '0;
                sub_next = 1'b0;
                rad_next = '0;
                // On a face axis the box's own radius is its half extent.
                if (face_a)
                begin
                    for (int n = 0; n < 3; n++)
                        u_next[n] = obb_sat_pkg::UVEC_W'(axa_rd[n]);
                    rad_next = RAD_W'(ha_rd) << (2 * obb_sat_pkg::FRAC_BITS);
                end
                else if (face_b)
                begin
                    for (int n = 0; n < 3; n++)
                        u_next[n] = obb_sat_pkg::UVEC_W'(axb_rd[n]);
                    rad_next = RAD_W'(hb_rd) << (2 * obb_sat_pkg::FRAC_BITS);
                end
            end
            obb_sat_pkg::B_XMUL:
            begin
                mul_req.start = 1'b1;
                mul_req.a = obb_sat_pkg::MA_W'(sub_reg ? axa_rd[c2] : axa_rd[c1]);
                mul_req.b = obb_sat_pkg::MB_W'(sub_reg ? axb_rd[c1] : axb_rd[c2]);
            end
            obb_sat_pkg::B_XWAIT:
            begin
                if (mul_rsp.done)
                begin
                    if (!sub_reg)
                    begin
                        acc_next = prod_ext;
                        sub_next = 1'b1;
                    end
                    else
                    begin
                        u_next[c_reg] = obb_sat_pkg::UVEC_W'(acc_reg - prod_ext);
                        sub_next      = 1'b0;
                        c_next        = c_last ? 2'd0 : c1;
                    end
                end
            end
            obb_sat_pkg::B_DIST:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = obb_sat_pkg::MA_W'(u_reg[c_reg]);
                mul_req.b     = d_reg[c_reg];
            end
            obb_sat_pkg::B_DWAIT:
            begin
                if (mul_rsp.done)
                begin
                    acc_next = dot_sum;
                    if (c_last)
                    begin
                        dist_next = dot_abs[obb_sat_pkg::DIST_W-1:0];
                        k_next    = '0;
                        c_next    = 2'd0;
                    end
                    else
                    begin
                        c_next = c1;
                    end
                end
            end
            obb_sat_pkg::B_PSEL:
            begin
                c_next = 2'd0;
                if (k_reg != EDGE_W'(obb_sat_pkg::NUM_EDGES) && !edge_used(t_reg, k_reg))
                    k_next = k_reg + EDGE_W'(1);
            end
            obb_sat_pkg::B_PMUL:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = obb_sat_pkg::MA_W'(u_reg[c_reg]);
                mul_req.b     = obb_sat_pkg::MB_W'(k_on_a ? axa_rd[c_reg] : axb_rd[c_reg]);
            end
            obb_sat_pkg::B_PWAIT:
            begin
                if (mul_rsp.done)
                begin
                    acc_next = dot_sum;
                    c_next   = c_last ? 2'd0 : c1;
                end
            end
            obb_sat_pkg::B_HMUL:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = $signed({1'b0, acc_abs[MAG_W-1:0]});
                mul_req.b     = $signed(obb_sat_pkg::MB_W'(k_on_a ? ha_rd : hb_rd));
            end
            obb_sat_pkg::B_HWAIT:
            begin
                if (mul_rsp.done)
                begin
                    rad_next = rad_reg + RAD_W'(mul_rsp.prod);
                    k_next   = k_reg + EDGE_W'(1);
                end
            end
            obb_sat_pkg::B_CMP:
            begin
                res_next = !separated;
                if (!separated && t_reg != AXIS_W'(obb_sat_pkg::NUM_AXES - 1))
                    t_next = t_reg + AXIS_W'(1);
            end
            obb_sat_pkg::B_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    collide_next   = res_reg;
                end
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= obb_sat_pkg::B_IDLE;
            t_reg         <= '0;
            k_reg         <= '0;
            c_reg         <= '0;
            sub_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            t_reg         <= t_next;
            k_reg         <= k_next;
            c_reg         <= c_next;
            sub_reg       <= sub_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg       <= d_next;
        u_reg       <= u_next;
        acc_reg     <= acc_next;
        dist_reg    <= dist_next;
        rad_reg     <= rad_next;
        res_reg     <= res_next;
        collide_reg <= collide_next;
    end

    // Store writes, one item per cycle while the sequencer is idle.
    always_ff @(posedge clk)
    begin
        if (store_wr)
        begin
            if (cmd.is_center)
            begin
                if (cmd.box)
                begin
                    cb_reg[0] <= cmd.x;
                    cb_reg[1] <= cmd.y;
                    cb_reg[2] <= cmd.z;
                end
                else
                begin
                    ca_reg[0] <= cmd.x;
                    ca_reg[1] <= cmd.y;
                    ca_reg[2] <= cmd.z;
                end
            end
            else if (cmd.box)
            begin
                axb_reg[cmd.slot][0] <= cmd.x;
                axb_reg[cmd.slot][1] <= cmd.y;
                axb_reg[cmd.slot][2] <= cmd.z;
                hb_reg[cmd.slot]     <= cmd.h;
            end
            else
            begin
                axa_reg[cmd.slot][0] <= cmd.x;
                axa_reg[cmd.slot][1] <= cmd.y;
                axa_reg[cmd.slot][2] <= cmd.z;
                ha_reg[cmd.slot]     <= cmd.h;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign collide   = collide_reg;

endmodule

`default_nettype wire

// ===== sv/obb_separating_axis_test.sv =====
// ----------------------------------------------------------------------------
// obb_separating_axis_test
// Oriented box overlap test over fifteen separating axes in exact fixed point.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Handshake             Fields
//   input     in          in_valid / in_ready   box, kind, x, y, z, half_length, last
//   output    out         out_valid / out_ready collide
//
// A loading item is taken into a two-entry queue; the back end drains it into
// the box stores while its sequencer is idle.
// The item marked last starts the test, which runs on one shared 32x33-bit
// multiplier: a face axis needs 15 products and a cross axis 25; a test with
// no separating axis runs all fifteen axes, and a test that finds one ends at
// that axis.
// Reset clears the queue, the sequencer and the output valid; box stores are
// unknown until loaded. Up to two items are still taken while a test runs,
// and a finished result waits in the output register while loading goes on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module obb_separating_axis_test (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 box,
    input  wire logic [1:0]           kind,
    input  wire obb_sat_pkg::coord_t  x,
    input  wire obb_sat_pkg::coord_t  y,
    input  wire obb_sat_pkg::coord_t  z,
    input  wire obb_sat_pkg::half_t   half_length,
    input  wire logic                 last,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic                      collide
);

    // Classified items pass from the front queue to the back end.
    obb_sat_pkg::cmd_t     cmd;
    logic                  cmd_valid;
    logic                  cmd_ready;

    // The back end borrows the multiplier one product at a time.
    obb_sat_pkg::mul_req_t mul_req;
    obb_sat_pkg::mul_rsp_t mul_rsp;

    obb_sat_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .box         (box),
        .kind        (kind),
        .x           (x),
        .y           (y),
        .z           (z),
        .half_length (half_length),
        .last        (last),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd)
    );

    obb_sat_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    obb_sat_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .mul_req   (mul_req),
        .mul_rsp   (mul_rsp),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .collide   (collide)
    );

endmodule

`default_nettype wire

// ===== sv/obb_sat_checker.sv =====
// ----------------------------------------------------------------------------
// obb_sat_assert
// Port-level checks of the separating axis test block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "obb_separating_axis_test_defines.svh"

module obb_sat_assert (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic collide
);

    `OBB_ASSERT_CLK(a_out_hold, clk, rst_n,
        out_valid && !out_ready |=> out_valid && $stable(collide),
        "result changed or dropped while stalled")
    `OBB_ASSERT_CLK(a_ready_fall, clk, rst_n,
        $fell(in_ready) |-> $past(in_valid && in_ready),
        "input queue filled without a transfer")
    `OBB_ASSERT_RAW(a_reset_quiet, clk,
        !rst_n && $past(!rst_n) |-> !out_valid && in_ready,
        "block not quiet in reset")

endmodule

bind obb_separating_axis_test obb_sat_assert u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .collide   (collide)
);

`default_nettype wire
